// ----- design/ltrs_pkg.sv -----
// Shared types, codes and constants of the literal text replace stream.
package ltrs_pkg;

  localparam int unsigned PAT_STORE = 8;
  localparam int unsigned REP_STORE = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SELECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_BYTES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_LEN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_LOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_HIGH    = 3'd6;

  localparam logic [1:0] STRAT_LITERAL = 2'd0;
  localparam logic [1:0] STRAT_PREPEND = 2'd1;
  localparam logic [1:0] STRAT_APPEND  = 2'd2;
  localparam logic [1:0] STRAT_ALWAYS  = 2'd3;

  localparam logic [2:0] SEL_ALL          = 3'd0;
  localparam logic [2:0] SEL_FIRST        = 3'd1;
  localparam logic [2:0] SEL_LAST         = 3'd2;
  localparam logic [2:0] SEL_EXCEPT_FIRST = 3'd3;
  localparam logic [2:0] SEL_EXCEPT_LAST  = 3'd4;

  typedef enum logic [2:0] {
    ROUTE_PASS,
    ROUTE_REP_B,
    ROUTE_PEND_B,
    ROUTE_B_REP,
    ROUTE_REP,
    ROUTE_NONE,
    ROUTE_MATCH
  } ltrs_route_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       unit_start;
    logic       unit_end;
    logic       is_first;
    logic       is_last;
    logic       is_ending;
  } ltrs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } ltrs_out_t;

  typedef struct packed {
    logic idle;
    logic capture;
    logic emit_b;
    logic emit_rep;
    logic emit_head;
    logic clr_cnt;
    logic finish;
  } ltrs_cmd_t;

  typedef struct packed {
    ltrs_route_e route;
    logic        can_emit;
    logic        cmp_all;
    logic        cnt_full;
    logic        cnt_zero;
    logic        cnt_one;
    logic        rep_last;
    logic        rlen_zero;
    logic        end_item;
  } ltrs_stat_t;

endpackage

// ----- design/ltrs_stream_if.sv -----
// Valid/ready stream channel carrying one payload per transaction.
interface ltrs_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/ltrs_dp.sv -----
// Datapath: configuration, working copies, pending window, output hold and register.
module ltrs_dp #(
  parameter int unsigned PATTERN_MAX     = ltrs_pkg::PAT_STORE,
  parameter int unsigned REPLACEMENT_MAX = ltrs_pkg::REP_STORE
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ltrs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ltrs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  ltrs_pkg::ltrs_in_t               in_item_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output ltrs_pkg::ltrs_out_t              out_item_o,
  input  ltrs_pkg::ltrs_cmd_t              cmd_i,
  output ltrs_pkg::ltrs_stat_t             stat_o
);

  localparam int unsigned PAT_DEPTH = (PATTERN_MAX < ltrs_pkg::PAT_STORE) ?
                                      PATTERN_MAX : ltrs_pkg::PAT_STORE;
  localparam int unsigned REP_DEPTH = (REPLACEMENT_MAX < ltrs_pkg::REP_STORE) ?
                                      REPLACEMENT_MAX : ltrs_pkg::REP_STORE;
  localparam int unsigned CNT_W = $clog2(PAT_DEPTH + 1);
  localparam int unsigned IDX_W = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;

  // configuration registers
  logic [1:0]  cfg_strat_q;
  logic [2:0]  cfg_lsel_q;
  logic [3:0]  cfg_plen_q;
  logic [63:0] cfg_pat_q;
  logic [4:0]  cfg_rlen_q;
  logic [63:0] cfg_rlo_q;
  logic [63:0] cfg_rhi_q;

  // working copies
  logic [1:0]       w_strat_q;
  logic [CNT_W-1:0] w_plen_q;
  logic [4:0]       w_rlen_q;
  logic [63:0]      w_pat_q;
  logic [127:0]     w_rep_q;

  logic [7:0]       win_q [PAT_DEPTH];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             applies_q;
  logic             tail_q, tail_d;
  logic [3:0]       rep_idx_q;

  logic [7:0] b_q;
  logic       end_q;
  logic       set_tail_q;

  logic       hold_v_q;
  logic [7:0] hold_b_q;
  logic       out_v_q;
  logic [7:0] out_b_q;
  logic       out_last_q;

  logic             sel_applies;
  logic [CNT_W-1:0] plen_c;
  logic [4:0]       rlen_c;
  logic             applies_n;
  logic             tail_n;
  logic [1:0]       strat_n;
  logic [4:0]       rlen_n;
  logic [CNT_W-1:0] cnt_n;
  logic             set_tail;
  ltrs_pkg::ltrs_route_e route;
  logic             out_free;
  logic             can_emit;
  logic             emit;
  logic             flush;
  logic [7:0]       emit_b;
  logic             cmp_all;

  always_comb begin
    unique case (cfg_lsel_q)
      ltrs_pkg::SEL_ALL:          sel_applies = 1'b1;
      ltrs_pkg::SEL_FIRST:        sel_applies = in_item_i.is_first;
      ltrs_pkg::SEL_LAST:         sel_applies = in_item_i.is_last;
      ltrs_pkg::SEL_EXCEPT_FIRST: sel_applies = !in_item_i.is_first;
      ltrs_pkg::SEL_EXCEPT_LAST:  sel_applies = !in_item_i.is_last;
      default:                    sel_applies = 1'b0;
    endcase
  end

  always_comb begin
    if (cfg_plen_q == 4'd0) begin
      plen_c = CNT_W'(1);
    end else if (cfg_plen_q > 4'(PAT_DEPTH)) begin
      plen_c = CNT_W'(PAT_DEPTH);
    end else begin
      plen_c = CNT_W'(cfg_plen_q);
    end
    rlen_c = (cfg_rlen_q > 5'(REP_DEPTH)) ? 5'(REP_DEPTH) : cfg_rlen_q;
  end

  // route of the incoming transaction, with the effects of a unit start applied
  always_comb begin
    applies_n = in_item_i.unit_start ? sel_applies : applies_q;
    tail_n    = in_item_i.unit_start ? 1'b0 : tail_q;
    strat_n   = in_item_i.unit_start ? cfg_strat_q : w_strat_q;
    rlen_n    = in_item_i.unit_start ? rlen_c : w_rlen_q;
    cnt_n     = in_item_i.unit_start ? '0 : cnt_q;
    set_tail  = 1'b0;
    route     = ltrs_pkg::ROUTE_PASS;
    if (!applies_n || tail_n) begin
      route = ltrs_pkg::ROUTE_PASS;
    end else if (strat_n == ltrs_pkg::STRAT_PREPEND) begin
      if (in_item_i.unit_start && rlen_n != 5'd0) begin
        route = ltrs_pkg::ROUTE_REP_B;
      end
    end else if (in_item_i.is_ending) begin
      set_tail = 1'b1;
      if (strat_n == ltrs_pkg::STRAT_LITERAL) begin
        if (cnt_n != '0) begin
          route = ltrs_pkg::ROUTE_PEND_B;
        end
      end else if (rlen_n != 5'd0) begin
        route = ltrs_pkg::ROUTE_REP_B;
      end
    end else if (strat_n == ltrs_pkg::STRAT_LITERAL) begin
      route = ltrs_pkg::ROUTE_MATCH;
    end else if (strat_n == ltrs_pkg::STRAT_APPEND) begin
      if (in_item_i.unit_end && rlen_n != 5'd0) begin
        route = ltrs_pkg::ROUTE_B_REP;
      end
    end else begin
      route = (in_item_i.unit_end && rlen_n != 5'd0) ?
              ltrs_pkg::ROUTE_REP : ltrs_pkg::ROUTE_NONE;
    end
  end

  always_comb begin
    cmp_all = 1'b1;
    for (int i = 0; i < PAT_DEPTH; i++) begin
      if ((CNT_W'(i) < cnt_q) && (win_q[i] != w_pat_q[8*i +: 8])) begin
        cmp_all = 1'b0;
      end
    end
  end

  assign out_free = !out_v_q || out_ready_i;
  assign can_emit = !hold_v_q || out_free;
  assign emit     = cmd_i.emit_b || cmd_i.emit_rep || cmd_i.emit_head;
  assign flush    = cmd_i.idle && hold_v_q && out_free;

  always_comb begin
    if (cmd_i.emit_b) begin
      emit_b = b_q;
    end else if (cmd_i.emit_rep) begin
      emit_b = w_rep_q[8*rep_idx_q +: 8];
    end else begin
      emit_b = win_q[0];
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    tail_d = tail_q;
    if (cmd_i.capture) begin
      cnt_d  = (route == ltrs_pkg::ROUTE_MATCH) ? cnt_n + CNT_W'(1) : cnt_n;
      tail_d = tail_n;
    end else begin
      if (cmd_i.emit_head) begin
        cnt_d = cnt_q - CNT_W'(1);
      end
      if (cmd_i.clr_cnt) begin
        cnt_d = '0;
      end
      if (cmd_i.finish) begin
        if (end_q) begin
          cnt_d  = '0;
          tail_d = 1'b0;
        end else if (set_tail_q) begin
          tail_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_strat_q <= ltrs_pkg::STRAT_LITERAL;
      cfg_lsel_q  <= ltrs_pkg::SEL_ALL;
      cfg_plen_q  <= 4'd1;
      cfg_pat_q   <= '0;
      cfg_rlen_q  <= '0;
      cfg_rlo_q   <= '0;
      cfg_rhi_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ltrs_pkg::CFG_STRATEGY:    cfg_strat_q <= cfg_data_i[1:0];
        ltrs_pkg::CFG_LINE_SELECT: cfg_lsel_q  <= cfg_data_i[2:0];
        ltrs_pkg::CFG_PAT_LEN:     cfg_plen_q  <= cfg_data_i[3:0];
        ltrs_pkg::CFG_PAT_BYTES:   cfg_pat_q   <= cfg_data_i;
        ltrs_pkg::CFG_REP_LEN:     cfg_rlen_q  <= cfg_data_i[4:0];
        ltrs_pkg::CFG_REP_LOW:     cfg_rlo_q   <= cfg_data_i;
        ltrs_pkg::CFG_REP_HIGH:    cfg_rhi_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_strat_q <= ltrs_pkg::STRAT_LITERAL;
      w_plen_q  <= CNT_W'(1);
      w_rlen_q  <= '0;
      cnt_q     <= '0;
      applies_q <= 1'b0;
      tail_q    <= 1'b0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      tail_q <= tail_d;
      if (cmd_i.capture && in_item_i.unit_start) begin
        w_strat_q <= cfg_strat_q;
        w_plen_q  <= plen_c;
        w_rlen_q  <= rlen_c;
        applies_q <= sel_applies;
      end
      if (emit) begin
        hold_v_q <= 1'b1;
        if (hold_v_q) begin
          out_v_q <= 1'b1;
        end else if (out_ready_i) begin
          out_v_q <= 1'b0;
        end
      end else if (flush) begin
        hold_v_q <= 1'b0;
        out_v_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      b_q        <= in_item_i.data_byte;
      end_q      <= in_item_i.unit_end;
      set_tail_q <= set_tail;
      rep_idx_q  <= '0;
      if (in_item_i.unit_start) begin
        w_pat_q <= cfg_pat_q;
        w_rep_q <= {cfg_rhi_q, cfg_rlo_q};
      end
      if (route == ltrs_pkg::ROUTE_MATCH) begin
        win_q[cnt_n[IDX_W-1:0]] <= in_item_i.data_byte;
      end
    end else begin
      if (cmd_i.emit_rep) begin
        rep_idx_q <= rep_idx_q + 4'd1;
      end
      if (cmd_i.emit_head) begin
        for (int i = 0; i < PAT_DEPTH - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
      end
    end
    if (emit) begin
      hold_b_q <= emit_b;
      if (hold_v_q) begin
        out_b_q    <= hold_b_q;
        out_last_q <= 1'b0;
      end
    end else if (flush) begin
      out_b_q    <= hold_b_q;
      out_last_q <= end_q;
    end
  end

  assign out_valid_o         = out_v_q;
  assign out_item_o.out_byte = out_b_q;
  assign out_item_o.out_last = out_last_q;

  assign stat_o.route     = route;
  assign stat_o.can_emit  = can_emit;
  assign stat_o.cmp_all   = cmp_all;
  assign stat_o.cnt_full  = (cnt_q == w_plen_q);
  assign stat_o.cnt_zero  = (cnt_q == '0);
  assign stat_o.cnt_one   = (cnt_q == CNT_W'(1));
  assign stat_o.rep_last  = (({1'b0, rep_idx_q} + 5'd1) == w_rlen_q);
  assign stat_o.rlen_zero = (w_rlen_q == 5'd0);
  assign stat_o.end_item  = end_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= w_plen_q)
    else $error("pending count above pattern length");

  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_head |-> cnt_q != '0)
    else $error("head emitted from empty window");

  a_rep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_rep |-> ({1'b0, rep_idx_q} < w_rlen_q))
    else $error("replacement index out of range");

  a_hold_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && hold_v_q) |=> out_v_q && hold_v_q)
    else $error("held byte lost on emit");

endmodule

// ----- design/ltrs_ctrl.sv -----
// Controller: sequences the output bytes of each accepted transaction.
module ltrs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ltrs_pkg::ltrs_stat_t  stat_i,
  output ltrs_pkg::ltrs_cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_EMIT_B    = 3'd1;
  localparam logic [2:0] S_EMIT_REP  = 3'd2;
  localparam logic [2:0] S_EMIT_PEND = 3'd3;
  localparam logic [2:0] S_MATCH     = 3'd4;
  localparam logic [2:0] S_SKIP      = 3'd5;

  logic [2:0]            state_q, state_d;
  ltrs_pkg::ltrs_route_e route_q, route_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    route_d    = route_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.idle = 1'b1;
        in_ready_o = stat_i.can_emit;
        if (in_valid_i && stat_i.can_emit) begin
          cmd_o.capture = 1'b1;
          route_d       = stat_i.route;
          case (stat_i.route) inside
            ltrs_pkg::ROUTE_PASS, ltrs_pkg::ROUTE_B_REP: state_d = S_EMIT_B;
            ltrs_pkg::ROUTE_REP_B, ltrs_pkg::ROUTE_REP:  state_d = S_EMIT_REP;
            ltrs_pkg::ROUTE_PEND_B:                      state_d = S_EMIT_PEND;
            ltrs_pkg::ROUTE_MATCH:                       state_d = S_MATCH;
            default:                                     state_d = S_SKIP;
          endcase
        end
      end
      S_EMIT_B: begin
        if (stat_i.can_emit) begin
          cmd_o.emit_b = 1'b1;
          if (route_q == ltrs_pkg::ROUTE_B_REP) begin
            state_d = S_EMIT_REP;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        end
      end
      S_EMIT_REP: begin
        if (stat_i.can_emit) begin
          cmd_o.emit_rep = 1'b1;
          if (stat_i.rep_last) begin
            if (route_q == ltrs_pkg::ROUTE_REP_B) begin
              state_d = S_EMIT_B;
            end else begin
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end
          end
        end
      end
      S_EMIT_PEND: begin
        if (stat_i.can_emit) begin
          cmd_o.emit_head = 1'b1;
          if (stat_i.cnt_one) begin
            if (route_q == ltrs_pkg::ROUTE_PEND_B) begin
              state_d = S_EMIT_B;
            end else begin
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end
          end
        end
      end
      S_MATCH: begin
        if (stat_i.can_emit) begin
          if (stat_i.cnt_zero) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end else if (stat_i.cmp_all && stat_i.cnt_full) begin
            cmd_o.clr_cnt = 1'b1;
            if (stat_i.rlen_zero) begin
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end else begin
              state_d = S_EMIT_REP;
            end
          end else if (stat_i.cmp_all) begin
            if (stat_i.end_item) begin
              state_d = S_EMIT_PEND;
            end else begin
              cmd_o.finish = 1'b1;
              state_d      = S_IDLE;
            end
          end else begin
            cmd_o.emit_head = 1'b1;
          end
        end
      end
      S_SKIP: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      route_q <= ltrs_pkg::ROUTE_PASS;
    end else begin
      state_q <= state_d;
      route_q <= route_d;
    end
  end

  a_capture_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> state_q == S_IDLE && !cmd_o.finish)
    else $error("capture outside idle");

  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.emit_b, cmd_o.emit_rep, cmd_o.emit_head}) <= 1)
    else $error("more than one emit command");

  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == S_IDLE)
    else $error("finish without return to idle");

endmodule

// ----- design/literal_text_replace_stream.sv -----
// Streaming literal find/replace over text units: top level.
//
// Input channel in_i carries one byte of a text unit per transaction with
// unit start/end, first/last line and line-ending flags. Output channel
// out_o carries rewritten bytes; out_last marks the final byte of a unit.
// The configuration port writes register cfg_index_i with cfg_data_i when
// cfg_we_i is high; strategy, pattern and replacement take effect at the
// next unit start.
// A transaction is accepted in the idle state, then its output bytes are
// emitted one by one; literal matching adds window rescan steps, and a
// replacement is emitted byte by byte. The controller emits at most one
// byte per cycle, and only when the hold stage can take it, into a
// one-byte hold stage, which feeds the output register; the hold stage is
// what lets out_last be set on the true final byte of a unit.
// Reset clears the configuration to its defaults and empties the pending
// window and the output. When the receiver stalls, the output register
// and the hold stage fill and the controller waits; input is accepted
// again once the held byte can move.
module literal_text_replace_stream #(
  parameter int unsigned PATTERN_MAX     = ltrs_pkg::PAT_STORE,
  parameter int unsigned REPLACEMENT_MAX = ltrs_pkg::REP_STORE
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ltrs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ltrs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  ltrs_stream_if.sink                      in_i,
  ltrs_stream_if.source                    out_o
);

  ltrs_pkg::ltrs_cmd_t  cmd;
  ltrs_pkg::ltrs_stat_t stat;
  logic                 in_ready;
  logic                 out_valid;
  ltrs_pkg::ltrs_out_t  out_item;

  ltrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ltrs_dp #(
    .PATTERN_MAX     (PATTERN_MAX),
    .REPLACEMENT_MAX (REPLACEMENT_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_item;

endmodule

// ----- verif/literal_text_replace_stream_test.sv -----
// Self-checking testbench of the literal text replace stream, scoreboard and stimulus.
module literal_text_replace_stream_test;
  import ltrs_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned MAX_RESULTS   = 17;
  localparam int unsigned PHASES        = 12;
  localparam logic [2:0]  SEL_UNDEFINED = 3'd7;
  localparam logic [1:0]  STRATEGY_ORDER [4] = '{STRAT_LITERAL, STRAT_PREPEND,
                                                 STRAT_APPEND, STRAT_ALWAYS};

  typedef struct {
    logic [1:0]  strategy;
    logic [2:0]  line_select;
    logic [3:0]  pattern_length;
    logic [63:0] pattern_bytes;
    logic [4:0]  replacement_length;
    logic [63:0] replacement_low;
    logic [63:0] replacement_high;
  } rewrite_setting_t;

  class text_rewrite_board;
    logic [1:0]   reg_strategy;
    logic [2:0]   reg_select;
    logic [3:0]   reg_plen;
    logic [63:0]  reg_pattern;
    logic [4:0]   reg_rlen;
    logic [63:0]  reg_rep_low;
    logic [63:0]  reg_rep_high;
    logic [1:0]   unit_strategy;
    int unsigned  unit_plen;
    int unsigned  unit_rlen;
    logic [63:0]  unit_pattern;
    logic [127:0] unit_rep;
    logic [7:0]   window_q[$];
    bit           unit_rewrites;
    bit           tail_passed;
    ltrs_out_t    step_q[$];
    ltrs_out_t    expected_q[$];
    int unsigned  error_count;
    int unsigned  input_count;
    int unsigned  result_count;

    function new();
      reg_strategy  = STRAT_LITERAL;
      reg_select    = SEL_ALL;
      reg_plen      = 4'd1;
      reg_pattern   = '0;
      reg_rlen      = '0;
      reg_rep_low   = '0;
      reg_rep_high  = '0;
      unit_rewrites = 1'b0;
      tail_passed   = 1'b0;
      error_count   = 0;
      input_count   = 0;
      result_count  = 0;
      latch_unit();
    endfunction

    function void write_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_STRATEGY:    reg_strategy = value[1:0];
        CFG_LINE_SELECT: reg_select   = value[2:0];
        CFG_PAT_LEN:     reg_plen     = value[3:0];
        CFG_PAT_BYTES:   reg_pattern  = value;
        CFG_REP_LEN:     reg_rlen     = value[4:0];
        CFG_REP_LOW:     reg_rep_low  = value;
        CFG_REP_HIGH:    reg_rep_high = value;
        default: ;
      endcase
    endfunction

    function void latch_unit();
      unit_strategy = reg_strategy;
      unit_plen     = (reg_plen == 0) ? 1 : ((reg_plen > PAT_STORE) ? PAT_STORE : reg_plen);
      unit_rlen     = (reg_rlen > REP_STORE) ? REP_STORE : reg_rlen;
      unit_pattern  = reg_pattern;
      unit_rep      = {reg_rep_high, reg_rep_low};
    endfunction

    function void emit(input logic [7:0] b);
      ltrs_out_t r;
      r.out_byte = b;
      r.out_last = 1'b0;
      if (step_q.size() < MAX_RESULTS) step_q.push_back(r);
    endfunction

    function void emit_replacement();
      for (int unsigned i = 0; i < unit_rlen; i++) emit(unit_rep[8*i +: 8]);
    endfunction

    function void flush_window();
      while (window_q.size() > 0) emit(window_q.pop_front());
    endfunction

    function void match_step(input logic [7:0] b);
      int unsigned i;
      if (window_q.size() >= unit_plen) flush_window();
      window_q.push_back(b);
      while (window_q.size() > 0) begin
        i = 0;
        while (i < window_q.size() && window_q[i] == unit_pattern[8*i +: 8]) i++;
        if (i == window_q.size()) begin
          if (i == unit_plen) begin
            emit_replacement();
            window_q.delete();
          end
          break;
        end
        emit(window_q.pop_front());
      end
    endfunction

    function void note_input(input ltrs_in_t item);
      step_q.delete();
      input_count++;
      if (item.unit_start) begin
        latch_unit();
        window_q.delete();
        tail_passed = 1'b0;
        case (reg_select)
          SEL_ALL:          unit_rewrites = 1'b1;
          SEL_FIRST:        unit_rewrites = item.is_first;
          SEL_LAST:         unit_rewrites = item.is_last;
          SEL_EXCEPT_FIRST: unit_rewrites = !item.is_first;
          SEL_EXCEPT_LAST:  unit_rewrites = !item.is_last;
          default:          unit_rewrites = 1'b0;
        endcase
      end
      if (!unit_rewrites || tail_passed) begin
        emit(item.data_byte);
      end else if (unit_strategy == STRAT_PREPEND) begin
        if (item.unit_start) emit_replacement();
        emit(item.data_byte);
      end else if (item.is_ending) begin
        if (unit_strategy == STRAT_LITERAL) flush_window();
        else emit_replacement();
        emit(item.data_byte);
        tail_passed = 1'b1;
      end else if (unit_strategy == STRAT_LITERAL) begin
        match_step(item.data_byte);
        if (item.unit_end) flush_window();
      end else if (unit_strategy == STRAT_APPEND) begin
        emit(item.data_byte);
        if (item.unit_end) emit_replacement();
      end else begin
        if (item.unit_end) emit_replacement();
      end
      if (item.unit_end) begin
        if (step_q.size() > 0) step_q[step_q.size()-1].out_last = 1'b1;
        window_q.delete();
        tail_passed = 1'b0;
      end
      foreach (step_q[k]) expected_q.push_back(step_q[k]);
    endfunction

    function void check_result(input ltrs_out_t got);
      ltrs_out_t want;
      if (expected_q.size() == 0) begin
        $error("out_byte: expected none, actual %02h", got.out_byte);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        result_count++;
        if (got.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
          error_count++;
        end
        if (got.out_last !== want.out_last) begin
          $error("out_last: expected %0b, actual %0b", want.out_last, got.out_last);
          error_count++;
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  text_rewrite_board     board;
  int unsigned           src_idle_pct  = 7;
  int unsigned           sink_idle_pct = 57;
  int unsigned           cycle_count   = 0;
  int unsigned           setting_count = 0;

  ltrs_stream_if #(.T(ltrs_in_t))  in_if ();
  ltrs_stream_if #(.T(ltrs_out_t)) out_if ();

  literal_text_replace_stream u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) board.note_input(in_if.data);
      if (out_if.valid && out_if.ready) board.check_result(out_if.data);
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic send_item(input ltrs_in_t item);
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit start, input bit stop,
                           input bit first, input bit last, input bit ending);
    ltrs_in_t item;
    item.data_byte  = b;
    item.unit_start = start;
    item.unit_end   = stop;
    item.is_first   = first;
    item.is_last    = last;
    item.is_ending  = ending;
    send_item(item);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_setting(input rewrite_setting_t s);
    logic [CFG_DATA_W-1:0] value [int'(CFG_REP_HIGH) + 1];
    value[CFG_STRATEGY]    = CFG_DATA_W'(s.strategy);
    value[CFG_LINE_SELECT] = CFG_DATA_W'(s.line_select);
    value[CFG_PAT_LEN]     = CFG_DATA_W'(s.pattern_length);
    value[CFG_PAT_BYTES]   = s.pattern_bytes;
    value[CFG_REP_LEN]     = CFG_DATA_W'(s.replacement_length);
    value[CFG_REP_LOW]     = s.replacement_low;
    value[CFG_REP_HIGH]    = s.replacement_high;
    for (int i = CFG_STRATEGY; i <= CFG_REP_HIGH; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(i);
      cfg_data_i  <= value[i];
      @(posedge clk_i);
      board.write_register(CFG_IDX_W'(i), value[i]);
    end
    cfg_we_i <= 1'b0;
    setting_count++;
  endtask

  function automatic rewrite_setting_t directed_setting(input logic [1:0] strategy,
      input logic [2:0] line_select, input logic [3:0] pattern_length,
      input logic [63:0] pattern_bytes, input logic [4:0] replacement_length);
    rewrite_setting_t s;
    s.strategy           = strategy;
    s.line_select        = line_select;
    s.pattern_length     = pattern_length;
    s.pattern_bytes      = pattern_bytes;
    s.replacement_length = replacement_length;
    s.replacement_low    = {$urandom, $urandom};
    s.replacement_high   = {$urandom, $urandom};
    return s;
  endfunction

  function automatic int unsigned pattern_in_use(input logic [3:0] length);
    return (length == 0) ? 1 : ((length > PAT_STORE) ? PAT_STORE : length);
  endfunction

  function automatic rewrite_setting_t make_setting(input int unsigned phase,
                                                    input logic [2:0][7:0] alphabet);
    rewrite_setting_t s;
    int unsigned pick;
    int unsigned used;
    s.strategy = STRATEGY_ORDER[phase % 4];
    pick = $urandom_range(0, 11);
    s.line_select = (pick > 7) ? SEL_ALL : 3'(pick);
    if (phase == 0) begin
      s.pattern_length = 4'($urandom_range(2, 7));
    end else if (phase == 4) begin
      s.pattern_length = 4'(PAT_STORE);
    end else if (phase == 8 || $urandom_range(0, 4) == 0) begin
      s.pattern_length = ($urandom_range(0, 1) != 0) ? 4'd0 : 4'($urandom_range(9, 15));
    end else begin
      s.pattern_length = 4'($urandom_range(1, 8));
    end
    used = pattern_in_use(s.pattern_length);
    for (int k = 0; k < 8; k++) begin
      pick = $urandom_range(0, 19);
      if (k >= used) s.pattern_bytes[8*k +: 8] = 8'($urandom);
      else s.pattern_bytes[8*k +: 8] = alphabet[(pick < 10) ? 0 : ((pick < 17) ? 1 : 2)];
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) s.replacement_length = 5'd0;
    else if (pick == 1) s.replacement_length = 5'(REP_STORE);
    else if (pick == 2) s.replacement_length = 5'($urandom_range(17, 31));
    else s.replacement_length = 5'($urandom_range(1, 15));
    s.replacement_low  = {$urandom, $urandom};
    s.replacement_high = {$urandom, $urandom};
    return s;
  endfunction

  task automatic send_text_unit(input rewrite_setting_t s, input logic [2:0][7:0] alphabet,
                                inout int unsigned sent);
    logic [7:0]  text_q[$];
    ltrs_in_t    unit_q[$];
    ltrs_in_t    item;
    logic [31:0] noise;
    int unsigned used;
    int unsigned target;
    int unsigned pick;
    int unsigned cut;
    int unsigned shape;
    int unsigned ending_len;
    int unsigned extra;
    used   = pattern_in_use(s.pattern_length);
    target = $urandom_range(0, 10);
    while (text_q.size() < target) begin
      pick = $urandom_range(0, 9);
      cut  = (pick < 4) ? used : $urandom_range(1, used);
      if (pick < 6) begin
        for (int k = 0; k < cut; k++) text_q.push_back(s.pattern_bytes[8*k +: 8]);
      end else if (pick < 9) begin
        text_q.push_back(alphabet[$urandom_range(0, 2)]);
      end else begin
        text_q.push_back(8'($urandom));
      end
    end
    shape      = $urandom_range(0, 9);
    ending_len = (shape == 8) ? $urandom_range(1, 2) : $urandom_range(0, 2);
    if (text_q.size() == 0 && ending_len == 0) text_q.push_back(alphabet[0]);
    item.unit_start = 1'b0;
    item.unit_end   = 1'b0;
    foreach (text_q[k]) begin
      item.data_byte = text_q[k];
      item.is_first  = 1'($urandom);
      item.is_last   = 1'($urandom);
      item.is_ending = 1'b0;
      unit_q.push_back(item);
    end
    for (int k = 0; k < ending_len; k++) begin
      item.data_byte = (k + 1 == ending_len) ? 8'h0A : 8'h0D;
      item.is_first  = 1'($urandom);
      item.is_last   = 1'($urandom);
      item.is_ending = 1'b1;
      unit_q.push_back(item);
    end
    if (shape == 8) begin
      extra = $urandom_range(1, 2);
      for (int k = 0; k < extra; k++) begin
        item.data_byte = alphabet[$urandom_range(0, 2)];
        item.is_ending = 1'b0;
        unit_q.push_back(item);
      end
    end
    unit_q[0].unit_start = 1'b1;
    if (shape != 6) unit_q[unit_q.size()-1].unit_end = 1'b1;
    if (shape == 7) begin
      extra = $urandom_range(1, 3);
      for (int k = 0; k < extra; k++) begin
        item.data_byte = alphabet[$urandom_range(0, 2)];
        item.is_ending = 1'($urandom);
        item.unit_end  = (k + 1 == extra);
        unit_q.push_back(item);
      end
    end
    if (shape == 9) begin
      extra = $urandom_range(1, 3);
      for (int k = 0; k < extra; k++) begin
        noise = $urandom;
        item  = noise[$bits(ltrs_in_t)-1:0];
        unit_q.push_back(item);
      end
    end
    foreach (unit_q[k]) send_item(unit_q[k]);
    sent += unit_q.size();
  endtask

  initial begin
    rewrite_setting_t setting;
    logic [2:0][7:0]  alphabet;
    int unsigned      sent;
    int unsigned      budget;
    board = new();
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= CFG_STRATEGY;
    cfg_data_i   <= '0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00, 1, 0, 1, 0, 0);
    send_byte(8'hFF, 0, 1, 0, 1, 0);
    wait_drained();

    apply_setting(directed_setting(STRAT_LITERAL, SEL_FIRST, 4'd3,
                                   {40'hC35A0F99E1, 8'h62, 8'h61, 8'h61}, 5'd16));
    send_byte("a", 1, 0, 1, 0, 0);
    send_byte("a", 0, 0, 0, 1, 0);
    send_byte("a", 0, 0, 1, 1, 0);
    send_byte("b", 0, 0, 0, 0, 0);
    send_byte("x", 0, 0, 1, 0, 0);
    send_byte(8'h0A, 0, 1, 0, 0, 1);
    send_byte("a", 1, 0, 1, 0, 0);
    send_byte("a", 1, 0, 0, 0, 0);
    send_byte("b", 0, 1, 0, 0, 0);
    send_byte("a", 1, 0, 1, 0, 0);
    wait_drained();

    apply_setting(directed_setting(STRAT_PREPEND, SEL_LAST, 4'd1, 64'h0, 5'd4));
    send_byte("a", 0, 0, 0, 0, 0);
    send_byte("b", 0, 1, 0, 0, 0);
    send_byte("c", 1, 0, 0, 1, 0);
    send_byte(8'h0A, 0, 1, 0, 0, 1);
    send_byte("d", 0, 1, 0, 0, 0);
    wait_drained();

    apply_setting(directed_setting(STRAT_APPEND, SEL_EXCEPT_FIRST, 4'd1, 64'h0, 5'd20));
    send_byte("e", 1, 0, 0, 0, 0);
    send_byte(8'h0D, 0, 0, 1, 1, 1);
    send_byte("z", 0, 1, 0, 0, 0);
    wait_drained();

    apply_setting(directed_setting(STRAT_ALWAYS, SEL_EXCEPT_LAST, 4'd1, 64'h0, 5'd0));
    send_byte("g", 1, 1, 0, 0, 0);
    send_byte("h", 1, 1, 0, 1, 0);
    wait_drained();

    apply_setting(directed_setting(STRAT_LITERAL, SEL_ALL, 4'd0, 64'h6B, 5'd1));
    send_byte("k", 1, 1, 0, 0, 0);
    wait_drained();

    apply_setting(directed_setting(STRAT_LITERAL, SEL_UNDEFINED, 4'd1, 64'h6B, 5'd3));
    send_byte("k", 1, 1, 1, 1, 0);
    wait_drained();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      src_idle_pct  = (phase < 4) ? 7 : ((phase < 8) ? 57 : 0);
      sink_idle_pct = (phase < 4) ? 57 : ((phase < 8) ? 7 : 0);
      alphabet = {8'($urandom), 8'($urandom), 8'($urandom)};
      setting  = make_setting(phase, alphabet);
      apply_setting(setting);
      budget = (setting.strategy == STRAT_LITERAL) ? 45 : 18;
      sent   = 0;
      while (sent < budget) send_text_unit(setting, alphabet, sent);
      wait_drained();
    end

    $display("checked %0d output bytes produced from %0d input bytes",
             board.result_count, board.input_count);
    $display("%0d register settings over all strategies and three flow-control mixes",
             setting_count);
    if (board.error_count == 0 && board.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- literal_text_replace_stream.f -----
design/ltrs_pkg.sv
design/ltrs_stream_if.sv
design/ltrs_dp.sv
design/ltrs_ctrl.sv
design/literal_text_replace_stream.sv
verif/literal_text_replace_stream_test.sv
